>>> rtl/text_transcoder_to_utf8_assert.svh
// Assertion macros for the text transcoder checks.
`ifndef TEXT_TRANSCODER_TO_UTF8_ASSERT_SVH
`define TEXT_TRANSCODER_TO_UTF8_ASSERT_SVH

// Checked while out of reset.
`define T2U8_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("t2u8 check failed");

// Checked at every edge, reset included.
`define T2U8_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("t2u8 reset check failed");

`endif

>>> rtl/t2u8_pkg.sv
// Shared types, constants and the single-byte code page table for the transcoder.
package t2u8_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef logic [1:0] t_enc;
    localparam t_enc ENC_UTF8    = 2'd0;
    localparam t_enc ENC_UTF16LE = 2'd1;
    localparam t_enc ENC_UTF16BE = 2'd2;
    localparam t_enc ENC_CP1252  = 2'd3;

    localparam logic [CP_W-1:0] CP_TAB  = 21'h000009;
    localparam logic [CP_W-1:0] CP_LF   = 21'h00000A;
    localparam logic [CP_W-1:0] CP_FF   = 21'h00000C;
    localparam logic [CP_W-1:0] CP_CR   = 21'h00000D;
    localparam logic [CP_W-1:0] CP_DEL  = 21'h00007F;
    localparam logic [CP_W-1:0] CP_BOM  = 21'h00FEFF;
    localparam logic [CP_W-1:0] CP_REPL = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // LFs to send first, then optionally one code point in UTF-8
    typedef struct packed {
        logic [1:0]      lf_cnt;
        logic            has_cp;
        logic [CP_W-1:0] cp;
    } t_slot;

    typedef struct packed {
        t_slot s0;
        t_slot s1;
    } t_cmd;

    // 0x80-0x9F; zero marks an undefined byte
    function automatic logic [15:0] cp1252_map(input logic [4:0] idx);
        logic [15:0] r;
        case (idx)
            5'h00: r = 16'h20AC;
            5'h02: r = 16'h201A;
            5'h03: r = 16'h0192;
            5'h04: r = 16'h201E;
            5'h05: r = 16'h2026;
            5'h06: r = 16'h2020;
            5'h07: r = 16'h2021;
            5'h08: r = 16'h02C6;
            5'h09: r = 16'h2030;
            5'h0A: r = 16'h0160;
            5'h0B: r = 16'h2039;
            5'h0C: r = 16'h0152;
            5'h0E: r = 16'h017D;
            5'h11: r = 16'h2018;
            5'h12: r = 16'h2019;
            5'h13: r = 16'h201C;
            5'h14: r = 16'h201D;
            5'h15: r = 16'h2022;
            5'h16: r = 16'h2013;
            5'h17: r = 16'h2014;
            5'h18: r = 16'h02DC;
            5'h19: r = 16'h2122;
            5'h1A: r = 16'h0161;
            5'h1B: r = 16'h203A;
            5'h1C: r = 16'h0153;
            5'h1E: r = 16'h017E;
            5'h1F: r = 16'h0178;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/t2u8_front.sv
// Front end: decodes input bytes, tracks pending state and builds output commands.
module t2u8_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t2u8_pkg::t_in_item   i_in,
    output logic                 o_in_stall,
    input  logic                 i_cfg_valid,
    input  t2u8_pkg::t_enc       i_cfg_data,
    output logic                 o_cfg_ready,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t2u8_pkg::t_cmd       o_q_cmd
);

    typedef struct packed {
        logic                      valid;
        logic                      release_only;
        logic [t2u8_pkg::CP_W-1:0] cp;
    } t_event;

    typedef struct packed {
        t2u8_pkg::t_slot slot;
        logic            cr;
    } t_sink_res;

    function automatic t_event mk_sink(input logic [t2u8_pkg::CP_W-1:0] cp);
        t_event e;
        e.valid        = 1'b1;
        e.release_only = 1'b0;
        e.cp           = cp;
        return e;
    endfunction

    function automatic t_event mk_release();
        t_event e;
        e.valid        = 1'b1;
        e.release_only = 1'b1;
        e.cp           = '0;
        return e;
    endfunction

    // Line-ending normalisation and control filtering for one code point
    function automatic t_sink_res do_sink(input logic cr_in, input t_event ev);
        t_sink_res                 r;
        logic [t2u8_pkg::CP_W-1:0] cp;
        logic                      drop;
        r    = '0;
        r.cr = cr_in;
        cp   = ev.cp;
        drop = (cp < 21'h20) || (cp == t2u8_pkg::CP_DEL)
            || (cp >= 21'h80 && cp <= 21'h9F) || (cp == t2u8_pkg::CP_BOM);
        if (ev.valid) begin
            if (cr_in) begin
                r.slot.lf_cnt = 2'd1;
                r.cr          = 1'b0;
            end
            if (!ev.release_only && !(cr_in && cp == t2u8_pkg::CP_LF)) begin
                if (cp == t2u8_pkg::CP_CR) begin
                    r.cr = 1'b1;
                end else if (cp == t2u8_pkg::CP_FF) begin
                    r.slot.lf_cnt = r.slot.lf_cnt + 2'd2;
                end else if (cp == t2u8_pkg::CP_LF || cp == t2u8_pkg::CP_TAB) begin
                    r.slot.has_cp = 1'b1;
                    r.slot.cp     = cp;
                end else if (!drop) begin
                    r.slot.has_cp = 1'b1;
                    r.slot.cp     = (cp > t2u8_pkg::CP_MAX
                        || (cp >= 21'hD800 && cp <= 21'hDFFF)) ? t2u8_pkg::CP_REPL : cp;
                end
            end
        end
        return r;
    endfunction

    t2u8_pkg::t_enc            r_enc,   n_enc;
    logic [7:0]                r_held,  n_held;
    logic                      r_phase, n_phase;
    logic [9:0]                r_hs,    n_hs;
    logic                      r_hsp,   n_hsp;
    logic                      r_cr,    n_cr;
    logic [t2u8_pkg::CP_W-1:0] r_acc,   n_acc;
    logic [1:0]                r_left,  n_left;

    logic                      accept;
    logic [7:0]                b;
    logic [15:0]               u;
    logic [15:0]               map;
    logic [t2u8_pkg::CP_W-1:0] nacc;
    logic [10:0]               hi_plane;
    logic                      ok;
    logic                      start;
    t_event                    ev1, ev2;
    t_sink_res                 res1, res2;
    logic                      s1_used, s2_used;

    assign accept      = i_in_valid && !i_q_full;
    assign o_in_stall  = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign b           = i_in.in_byte;
    assign u           = (r_enc == t2u8_pkg::ENC_UTF16LE) ? {b, r_held} : {r_held, b};
    assign map         = t2u8_pkg::cp1252_map(b[4:0]);
    assign nacc        = {r_acc[14:0], b[5:0]};
    assign hi_plane    = {1'b0, r_hs} + 11'd64;

    always_comb begin
        n_enc   = r_enc;
        n_held  = r_held;
        n_phase = r_phase;
        n_hs    = r_hs;
        n_hsp   = r_hsp;
        n_acc   = r_acc;
        n_left  = r_left;
        ev1     = '0;
        ev2     = '0;
        ok      = 1'b0;
        start   = 1'b1;
        if (i_cfg_valid) begin
            n_enc   = i_cfg_data;
            n_held  = '0;
            n_phase = 1'b0;
            n_hs    = '0;
            n_hsp   = 1'b0;
            n_acc   = '0;
            n_left  = '0;
        end else if (accept) begin
            if (i_in.end_of_text) begin
                if (r_hsp || r_left != 2'd0) begin
                    ev1 = mk_sink(t2u8_pkg::CP_REPL);
                end
                ev2     = mk_release();
                n_held  = '0;
                n_phase = 1'b0;
                n_hs    = '0;
                n_hsp   = 1'b0;
                n_acc   = '0;
                n_left  = '0;
            end else begin
                case (r_enc)
                    t2u8_pkg::ENC_UTF8: begin
                        if (r_left != 2'd0) begin
                            ok = (b[7:6] == 2'b10);
                            if (r_left == 2'd3) begin
                                if (r_acc == 21'd0 && b < 8'h90) ok = 1'b0;
                                if (r_acc == 21'd4 && b > 8'h8F) ok = 1'b0;
                            end
                            if (r_left == 2'd2 && r_acc < 21'd16) begin
                                if (r_acc == 21'd0 && b < 8'hA0) ok = 1'b0;
                                if (r_acc == 21'hD && b > 8'h9F) ok = 1'b0;
                            end
                            if (ok) begin
                                start  = 1'b0;
                                n_acc  = nacc;
                                n_left = r_left - 2'd1;
                                if (r_left == 2'd1) begin
                                    ev1   = mk_sink(nacc);
                                    n_acc = '0;
                                end
                            end else begin
                                n_left = '0;
                                n_acc  = '0;
                                ev1    = mk_sink(t2u8_pkg::CP_REPL);
                            end
                        end
                        if (start) begin
                            if (b < 8'h80) begin
                                ev2 = mk_sink({13'd0, b});
                            end else if (b >= 8'hC2 && b <= 8'hDF) begin
                                ev2    = mk_release();
                                n_acc  = {16'd0, b[4:0]};
                                n_left = 2'd1;
                            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                                ev2    = mk_release();
                                n_acc  = {17'd0, b[3:0]};
                                n_left = 2'd2;
                            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                                ev2    = mk_release();
                                n_acc  = {18'd0, b[2:0]};
                                n_left = 2'd3;
                            end else begin
                                ev2 = mk_sink(t2u8_pkg::CP_REPL);
                            end
                        end
                    end
                    t2u8_pkg::ENC_CP1252: begin
                        if (b >= 8'h80 && b <= 8'h9F) begin
                            // undefined bytes leave a pending CR alone
                            if (map != 16'd0) ev1 = mk_sink({5'd0, map});
                        end else if (b != 8'h00) begin
                            // NUL is skipped the same way
                            ev1 = mk_sink({13'd0, b});
                        end
                    end
                    default: begin
                        if (!r_phase) begin
                            n_held  = b;
                            n_phase = 1'b1;
                        end else begin
                            n_held  = '0;
                            n_phase = 1'b0;
                            if (r_hsp) begin
                                n_hsp = 1'b0;
                                n_hs  = '0;
                                if (u >= 16'hDC00 && u <= 16'hDFFF) begin
                                    start = 1'b0;
                                    ev1   = mk_sink({hi_plane, u[9:0]});
                                end else begin
                                    ev1 = mk_sink(t2u8_pkg::CP_REPL);
                                end
                            end
                            if (start) begin
                                if (u >= 16'hD800 && u <= 16'hDBFF) begin
                                    ev2   = mk_release();
                                    n_hs  = u[9:0];
                                    n_hsp = 1'b1;
                                end else if (u >= 16'hDC00 && u <= 16'hDFFF) begin
                                    ev2 = mk_sink(t2u8_pkg::CP_REPL);
                                end else begin
                                    ev2 = mk_sink({5'd0, u});
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign res1    = do_sink(r_cr, ev1);
    assign res2    = do_sink(res1.cr, ev2);
    assign s1_used = (res1.slot.lf_cnt != 2'd0) || res1.slot.has_cp;
    assign s2_used = (res2.slot.lf_cnt != 2'd0) || res2.slot.has_cp;
    assign n_cr    = (accept && !i_cfg_valid) ? res2.cr : r_cr;

    // the back end expects the first slot filled whenever anything is sent
    always_comb begin
        if (s1_used) begin
            o_q_cmd.s0 = res1.slot;
            o_q_cmd.s1 = res2.slot;
        end else begin
            o_q_cmd.s0 = res2.slot;
            o_q_cmd.s1 = '0;
        end
    end

    assign o_q_push = accept && !i_cfg_valid && (s1_used || s2_used);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc   <= t2u8_pkg::ENC_UTF8;
            r_held  <= '0;
            r_phase <= 1'b0;
            r_hs    <= '0;
            r_hsp   <= 1'b0;
            r_cr    <= 1'b0;
            r_acc   <= '0;
            r_left  <= '0;
        end else begin
            r_enc   <= n_enc;
            r_held  <= n_held;
            r_phase <= n_phase;
            r_hs    <= n_hs;
            r_hsp   <= n_hsp;
            r_cr    <= n_cr;
            r_acc   <= n_acc;
            r_left  <= n_left;
        end
    end

endmodule

>>> rtl/t2u8_queue.sv
// Command queue between the decoding front end and the byte emitter.
module t2u8_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t2u8_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output t2u8_pkg::t_cmd  o_head,
    output logic            o_full,
    output logic            o_empty
);

    t2u8_pkg::t_cmd                r_mem [t2u8_pkg::QDEPTH];
    logic [t2u8_pkg::QAW-1:0]      r_wptr, r_rptr;
    logic [t2u8_pkg::QAW:0]        r_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == (t2u8_pkg::QAW+1)'(t2u8_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/t2u8_back.sv
// Back end: walks each command, sending one UTF-8 byte per cycle unless output stalls.
module t2u8_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t2u8_pkg::t_cmd       i_q_head,
    input  logic                 i_q_empty,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t2u8_pkg::t_out_item  o_out
);

    function automatic logic [1:0] last_idx(input logic [t2u8_pkg::CP_W-1:0] cp);
        logic [1:0] r;
        if (cp < 21'h80)         r = 2'd0;
        else if (cp < 21'h800)   r = 2'd1;
        else if (cp < 21'h10000) r = 2'd2;
        else                     r = 2'd3;
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [t2u8_pkg::CP_W-1:0] cp,
                                             input logic [1:0] k);
        logic [7:0] r;
        if (cp < 21'h80) begin
            r = cp[7:0];
        end else if (cp < 21'h800) begin
            r = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            case (k)
                2'd0:    r = {4'b1110, cp[15:12]};
                2'd1:    r = {2'b10, cp[11:6]};
                default: r = {2'b10, cp[5:0]};
            endcase
        end else begin
            case (k)
                2'd0:    r = {5'b11110, cp[20:18]};
                2'd1:    r = {2'b10, cp[17:12]};
                2'd2:    r = {2'b10, cp[11:6]};
                default: r = {2'b10, cp[5:0]};
            endcase
        end
        return r;
    endfunction

    t2u8_pkg::t_cmd      r_cur;
    logic                r_busy;
    logic                r_slot;
    logic [1:0]          r_lf;
    logic [1:0]          r_k;
    logic                r_ovalid;
    t2u8_pkg::t_out_item r_out;

    t2u8_pkg::t_slot     cur;
    logic                in_lf;
    logic [7:0]          cur_byte;
    logic                slot_done;
    logic                s1_empty;
    logic                last;
    logic                can_load;
    logic                emit;
    logic                pop;

    assign cur       = r_slot ? r_cur.s1 : r_cur.s0;
    assign in_lf     = (r_lf != 2'd0);
    assign cur_byte  = in_lf ? 8'h0A : utf8_byte(cur.cp, r_k);
    assign slot_done = in_lf ? (r_lf == 2'd1 && !cur.has_cp) : (r_k == last_idx(cur.cp));
    assign s1_empty  = (r_cur.s1.lf_cnt == 2'd0) && !r_cur.s1.has_cp;
    assign last      = slot_done && (r_slot || s1_empty);
    assign can_load  = !r_ovalid || !i_out_stall;
    assign emit      = r_busy && can_load;
    // next command is taken on the edge that sends the final byte of this one
    assign pop       = !i_q_empty && (!r_busy || (emit && last));

    assign o_q_pop     = pop;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= 1'b0;
            r_lf   <= '0;
            r_k    <= '0;
        end else if (pop) begin
            r_busy <= 1'b1;
            r_slot <= 1'b0;
            r_lf   <= i_q_head.s0.lf_cnt;
            r_k    <= '0;
        end else if (emit) begin
            if (last) begin
                r_busy <= 1'b0;
            end else if (slot_done) begin
                r_slot <= 1'b1;
                r_lf   <= r_cur.s1.lf_cnt;
                r_k    <= '0;
            end else if (in_lf) begin
                r_lf <= r_lf - 2'd1;
            end else begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) r_cur <= i_q_head;
        if (emit) begin
            r_out.out_byte    <= cur_byte;
            r_out.last_of_run <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

endmodule

>>> rtl/text_transcoder_to_utf8.sv
// Transcoder top level: raw UTF-8, UTF-16LE/BE or CP1252 bytes in, normalised UTF-8 out.
// An input request is taken every cycle while the four-entry command queue has room; the
// front end decodes it in that cycle and queues a command of up to two code points with
// leading LFs. The back end sends one output byte per cycle while the output is not
// stalled, so the sustained rate without stalls is one output byte per clock. An accepted
// item's command is written into the queue, then taken into the back end's command
// register, and its first byte then goes into the output register. Items that yield
// nothing (BOM, dropped controls, held bytes) queue no command. The input_encoding
// register may be written at any time the block is idle; the write port is always ready.
module text_transcoder_to_utf8 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t2u8_pkg::t_in_item   i_in,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t2u8_pkg::t_out_item  o_out,
    input  logic                 i_cfg_valid,
    input  t2u8_pkg::t_enc       i_cfg_data,
    output logic                 o_cfg_ready
);

`include "text_transcoder_to_utf8_assert.svh"

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    t2u8_pkg::t_cmd  q_cmd;
    t2u8_pkg::t_cmd  q_head;

    t2u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_cmd)
    );

    t2u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    t2u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_head    (q_head),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    `T2U8_ASSERT(a_queue_no_overflow, q_push |-> !q_full)
    `T2U8_ASSERT(a_queue_no_underflow, q_pop |-> !q_empty)
    `T2U8_ASSERT(a_cmd_not_empty, q_push |-> (q_cmd.s0.has_cp || q_cmd.s0.lf_cnt != 2'd0))
    `T2U8_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_out_valid)

endmodule
